FILE: rtl/core/twma_pkg.sv
// Shared constants, types and window setup for the triple-window moving average.
// Used by twma_div and triple_window_moving_average_core; depends on nothing.
package twma_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned AVG_W    = 24;
  localparam int unsigned FRAC_W   = 8;

  // History and window lengths
  localparam int unsigned HIST_DEPTH   = 900;
  localparam int unsigned SHORT_WINDOW = 60;
  localparam int unsigned MID_WINDOW   = 300;

  // A window of zero acts as one; a window past the history is clipped to it.
  function automatic int unsigned eff_win(int unsigned w);
    if (w < 1) return 1;
    if (w > HIST_DEPTH) return HIST_DEPTH;
    return w;
  endfunction

  localparam int unsigned SHORT_EFF = eff_win(SHORT_WINDOW);
  localparam int unsigned MID_EFF   = eff_win(MID_WINDOW);
  localparam int unsigned LONG_EFF  = HIST_DEPTH;

  // Full-length windows drop the entry being overwritten
  localparam bit SHORT_FULL = (SHORT_EFF == HIST_DEPTH);
  localparam bit MID_FULL   = (MID_EFF == HIST_DEPTH);

  localparam int unsigned PTR_W = $clog2(HIST_DEPTH);
  localparam int unsigned WIN_W = $clog2(HIST_DEPTH + 1);

  localparam longint unsigned SAMPLE_MAX = (64'd1 << SAMPLE_W) - 64'd1;

  // Running sum widths follow the largest possible window total
  localparam int unsigned SUM_S_W = $clog2(longint'(SHORT_EFF) * SAMPLE_MAX + 1);
  localparam int unsigned SUM_M_W = $clog2(longint'(MID_EFF) * SAMPLE_MAX + 1);
  localparam int unsigned SUM_L_W = $clog2(longint'(LONG_EFF) * SAMPLE_MAX + 1);

  // Dividend is sum << FRAC_W; reciprocals are floor(2^NUM_W / window)
  localparam int unsigned NUM_W   = SUM_L_W + FRAC_W;
  localparam int unsigned RECIP_W = NUM_W + 1;

  localparam longint unsigned RECIP_SHORT = (64'd1 << NUM_W) / SHORT_EFF;
  localparam longint unsigned RECIP_MID   = (64'd1 << NUM_W) / MID_EFF;
  localparam longint unsigned RECIP_LONG  = (64'd1 << NUM_W) / LONG_EFF;

  // Offsets that turn a write position into the leaving position, mod depth
  localparam int unsigned LEAVE_OFS_S = HIST_DEPTH - SHORT_EFF;
  localparam int unsigned LEAVE_OFS_M = HIST_DEPTH - MID_EFF;

  // Result queue
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned OUTS_W   = $clog2(RQ_DEPTH + 1);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [AVG_W-1:0]    avg_t;

  typedef struct packed {
    avg_t avg_short;
    avg_t avg_mid;
    avg_t avg_long;
  } result_t;

  // Per-item sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_S,
    ST_RD_M,
    ST_UPD
  } seq_state_e;

endpackage

FILE: rtl/core/triple_window_moving_average_core.sv
// Triple-window moving average: sample history memory, running window sums, dividers
// and result queue. Depends on twma_pkg and twma_div.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-----------------------------------
//  in      | input     | in_valid_i / in_stall_o     | sample_i
//  out     | output    | out_valid_o / out_stall_i   | avg_short_o, avg_mid_o, avg_long_o
//
// A new request is taken only in the idle or update state: the history memory has one read
// port and each sample needs three reads (overwritten entry, short-window and mid-window
// leaving entries). A result passes the read states, sum update, divider stages and queue.
// No clearing pass after reset: a wrap flag and the write pointer mark written entries,
// unwritten ones read as zero. in_stall_o is high in the two read states of each request.
// Up to 4 requests may be outstanding, in the pipeline or queued; with 4 outstanding,
// in_stall_o stays high until a result leaves.
module triple_window_moving_average_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [twma_pkg::SAMPLE_W-1:0] sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [twma_pkg::AVG_W-1:0]   avg_short_o,
  output logic [twma_pkg::AVG_W-1:0]   avg_mid_o,
  output logic [twma_pkg::AVG_W-1:0]   avg_long_o
);
  import twma_pkg::*;

  // Sequencer and handshake
  seq_state_e state_q, state_d;
  logic       in_acc, out_acc, seq_free;
  logic [OUTS_W-1:0] outs_q, outs_d;

  // Write pointer and fill tracking
  ptr_t wp_q, wp_d;
  logic wrap_q, wrap_d;

  // Item in flight
  ptr_t    item_pos_q;
  logic    item_wrap_q;
  sample_t sample_q;
  sample_t old_q, lvs_q;

  // History memory
  sample_t hist_mem [HIST_DEPTH];
  ptr_t    rd_addr;
  logic    rd_ok, rd_ok_q;
  sample_t rd_data_q, rd_val;
  logic    mem_we, cap_old, cap_lvs, div_go_q;

  // Leaving positions
  logic [PTR_W:0] lv_s_sum, lv_m_sum;
  ptr_t           lv_s_addr, lv_m_addr;
  logic           lv_s_ok, lv_m_ok;

  // Running sums
  logic [SUM_S_W-1:0] sum_s_q, sum_s_d;
  logic [SUM_M_W-1:0] sum_m_q, sum_m_d;
  logic [SUM_L_W-1:0] sum_l_q, sum_l_d;
  sample_t            out_s, out_m;

  // Dividers and result queue
  logic    dv_s, dv_m, dv_l, rq_push;
  avg_t    q_s, q_m, q_l;
  result_t rq_mem [RQ_DEPTH];
  logic [RQ_PTR_W:0] rq_wr_q, rq_rd_q;
  result_t rq_head;

  // Handshakes
  assign seq_free   = (state_q == ST_IDLE) || (state_q == ST_UPD);
  assign in_stall_o = !(seq_free && (outs_q != OUTS_W'(RQ_DEPTH)));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (rq_wr_q != rq_rd_q);
  assign out_acc    = out_valid_o && !out_stall_i;

  // Leaving positions: pos - w mod depth; already written if the history wrapped or pos >= w
  assign lv_s_sum  = {1'b0, item_pos_q} + (PTR_W + 1)'(LEAVE_OFS_S);
  assign lv_m_sum  = {1'b0, item_pos_q} + (PTR_W + 1)'(LEAVE_OFS_M);
  assign lv_s_ok   = item_wrap_q || (lv_s_sum >= (PTR_W + 1)'(HIST_DEPTH));
  assign lv_m_ok   = item_wrap_q || (lv_m_sum >= (PTR_W + 1)'(HIST_DEPTH));
  assign lv_s_addr = lv_s_ok && !item_wrap_q ? PTR_W'(lv_s_sum - (PTR_W + 1)'(HIST_DEPTH))
                   : (lv_s_sum >= (PTR_W + 1)'(HIST_DEPTH))
                     ? PTR_W'(lv_s_sum - (PTR_W + 1)'(HIST_DEPTH)) : PTR_W'(lv_s_sum);
  assign lv_m_addr = (lv_m_sum >= (PTR_W + 1)'(HIST_DEPTH))
                   ? PTR_W'(lv_m_sum - (PTR_W + 1)'(HIST_DEPTH)) : PTR_W'(lv_m_sum);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RD_S;
      ST_RD_S: state_d = ST_RD_M;
      ST_RD_M: state_d = ST_UPD;
      ST_UPD:  state_d = in_acc ? ST_RD_S : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: read port address, write enable and capture strobes
  always_comb begin
    rd_addr = wp_q;
    rd_ok   = wrap_q;
    mem_we  = 1'b0;
    cap_old = 1'b0;
    cap_lvs = 1'b0;
    case (state_q)
      ST_RD_S: begin
        rd_addr = lv_s_addr;
        rd_ok   = lv_s_ok;
        cap_old = 1'b1;
      end
      ST_RD_M: begin
        rd_addr = lv_m_addr;
        rd_ok   = lv_m_ok;
        cap_lvs = 1'b1;
      end
      ST_UPD: begin
        mem_we = 1'b1;
      end
      default: begin
        rd_addr = wp_q;
        rd_ok   = wrap_q;
      end
    endcase
  end

  // Unwritten entries read as zero
  assign rd_val = rd_ok_q ? rd_data_q : '0;

  // Write pointer advances at accept
  always_comb begin
    wp_d   = wp_q;
    wrap_d = wrap_q;
    if (in_acc) begin
      if (wp_q == PTR_W'(HIST_DEPTH - 1)) begin
        wp_d   = '0;
        wrap_d = 1'b1;
      end else begin
        wp_d = wp_q + PTR_W'(1);
      end
    end
  end

  // Window sum update: drop the leaving sample, add the new one
  assign out_s = SHORT_FULL ? old_q : lvs_q;
  assign out_m = MID_FULL ? old_q : rd_val;

  always_comb begin
    sum_s_d = sum_s_q;
    sum_m_d = sum_m_q;
    sum_l_d = sum_l_q;
    if (state_q == ST_UPD) begin
      sum_s_d = SUM_S_W'({1'b0, sum_s_q} + (SUM_S_W + 1)'(sample_q) - (SUM_S_W + 1)'(out_s));
      sum_m_d = SUM_M_W'({1'b0, sum_m_q} + (SUM_M_W + 1)'(sample_q) - (SUM_M_W + 1)'(out_m));
      sum_l_d = SUM_L_W'({1'b0, sum_l_q} + (SUM_L_W + 1)'(sample_q) - (SUM_L_W + 1)'(old_q));
    end
  end

  // Outstanding request count
  always_comb begin
    outs_d = outs_q;
    if (in_acc && !out_acc) outs_d = outs_q + OUTS_W'(1);
    else if (!in_acc && out_acc) outs_d = outs_q - OUTS_W'(1);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wp_q     <= '0;
      wrap_q   <= 1'b0;
      sum_s_q  <= '0;
      sum_m_q  <= '0;
      sum_l_q  <= '0;
      outs_q   <= '0;
      div_go_q <= 1'b0;
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      wrap_q   <= wrap_d;
      sum_s_q  <= sum_s_d;
      sum_m_q  <= sum_m_d;
      sum_l_q  <= sum_l_d;
      outs_q   <= outs_d;
      div_go_q <= (state_q == ST_UPD);
      if (rq_push) rq_wr_q <= rq_wr_q + (RQ_PTR_W + 1)'(1);
      if (out_acc) rq_rd_q <= rq_rd_q + (RQ_PTR_W + 1)'(1);
    end
  end

  // Item payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_pos_q  <= wp_q;
      item_wrap_q <= wrap_q;
      sample_q    <= sample_i;
    end
    if (cap_old) old_q <= rd_val;
    if (cap_lvs) lvs_q <= rd_val;
    rd_ok_q <= rd_ok;
  end

  // History memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) hist_mem[item_pos_q] <= sample_q;
    rd_data_q <= hist_mem[rd_addr];
  end

  // Dividers, one per window
  twma_div u_div_short (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_go_q),
    .sum_i   (SUM_L_W'(sum_s_q)),
    .recip_i (RECIP_W'(RECIP_SHORT)),
    .win_i   (WIN_W'(SHORT_EFF)),
    .valid_o (dv_s),
    .quot_o  (q_s)
  );

  twma_div u_div_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_go_q),
    .sum_i   (SUM_L_W'(sum_m_q)),
    .recip_i (RECIP_W'(RECIP_MID)),
    .win_i   (WIN_W'(MID_EFF)),
    .valid_o (dv_m),
    .quot_o  (q_m)
  );

  twma_div u_div_long (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_go_q),
    .sum_i   (sum_l_q),
    .recip_i (RECIP_W'(RECIP_LONG)),
    .win_i   (WIN_W'(LONG_EFF)),
    .valid_o (dv_l),
    .quot_o  (q_l)
  );

  // Result queue; outstanding limit guarantees room on push
  assign rq_push = dv_s && dv_m && dv_l;

  always_ff @(posedge clk_i) begin
    if (rq_push) rq_mem[rq_wr_q[RQ_PTR_W-1:0]] <= '{avg_short: q_s, avg_mid: q_m, avg_long: q_l};
  end

  assign rq_head     = rq_mem[rq_rd_q[RQ_PTR_W-1:0]];
  assign avg_short_o = rq_head.avg_short;
  assign avg_mid_o   = rq_head.avg_mid;
  assign avg_long_o  = rq_head.avg_long;

endmodule

FILE: rtl/core/twma_div.sv
// Pipelined divide of a window sum by its constant window length (reciprocal multiply
// plus one correction step). Depends on twma_pkg.
module twma_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [twma_pkg::SUM_L_W-1:0]   sum_i,
  input  logic [twma_pkg::RECIP_W-1:0]   recip_i,
  input  logic [twma_pkg::WIN_W-1:0]     win_i,
  output logic                           valid_o,
  output logic [twma_pkg::AVG_W-1:0]     quot_o
);
  import twma_pkg::*;

  localparam int unsigned PROD1_W = SUM_L_W + RECIP_W;
  localparam int unsigned PROD2_W = AVG_W + WIN_W;

  logic               v1_q, v2_q, v3_q;
  logic [PROD1_W-1:0] prod1;
  avg_t               q1_d, q1_q, q2_q, quot_d, quot_q;
  logic [NUM_W-1:0]   num1_q, num2_q, rem;
  logic [WIN_W-1:0]   win1_q, win2_q;
  logic [PROD2_W-1:0] prod2_d, prod2_q;

  // Stage 1: estimate, low by at most one
  assign prod1 = PROD1_W'(sum_i) * PROD1_W'(recip_i);
  assign q1_d  = AVG_W'(prod1 >> (NUM_W - FRAC_W));

  // Stage 2: back-multiply the estimate
  assign prod2_d = PROD2_W'(q1_q) * PROD2_W'(win1_q);

  // Stage 3: remainder check
  assign rem    = num2_q - NUM_W'(prod2_q);
  assign quot_d = (rem >= NUM_W'(win2_q)) ? q2_q + AVG_W'(1) : q2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q    <= q1_d;
    num1_q  <= {sum_i, FRAC_W'(0)};
    win1_q  <= win_i;
    prod2_q <= prod2_d;
    q2_q    <= q1_q;
    num2_q  <= num1_q;
    win2_q  <= win1_q;
    quot_q  <= quot_d;
  end

  assign valid_o = v3_q;
  assign quot_o  = quot_q;

endmodule
